// ===== hdl/ptb_pkg.sv =====
// Shared constants, types and state codes for the periodic ticker bank.
`default_nettype none

package ptb_pkg;

   // Bank size and result limit
   localparam int TICKER_COUNT = 16;
   localparam int MAX_RESULTS  = 16;

   // Field widths
   localparam int SEL_W   = 4;
   localparam int CNT16_W = 16;
   localparam int FIRE_W  = 4;

   // Ticker index and fire count widths
   localparam int IDX_W = (TICKER_COUNT > 1) ? $clog2(TICKER_COUNT) : 1;
   localparam int RES_W = $clog2(MAX_RESULTS + 1);

   // Request kinds
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   // Repeat count meaning fire forever
   localparam logic signed [CNT16_W-1:0] REPEAT_FOREVER = -16'sd1;

   // Values written into one ticker by a load request
   typedef struct packed {
      logic [CNT16_W-1:0]        delay;
      logic [CNT16_W-1:0]        period;
      logic signed [CNT16_W-1:0] repeats;
   } ptb_load_type;

   // Controller outputs toward the cell row
   typedef struct packed {
      logic load_go;
      logic sweep_go;
   } ptb_ctl_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } ptb_state_type;

endpackage : ptb_pkg

`default_nettype wire

// ===== hdl/ptb_cell.sv =====
// One ticker cell: holds one ticker's counters and passes the visit token on.
`default_nettype none

module ptb_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load_we,
   input  wire ptb_pkg::ptb_load_type load_data,
   input  wire logic                  visit_i,
   output logic                       visit_o,
   output logic                       fire_o
);
   import ptb_pkg::*;

   logic [CNT16_W-1:0]        delay_ff,  delay_in;
   logic [CNT16_W-1:0]        left_ff,   left_in;
   logic [CNT16_W-1:0]        reload_ff, reload_in;
   logic signed [CNT16_W-1:0] rep_ff,    rep_in;
   logic                      visit_ff;
   logic                      active;
   logic                      forever_run;

   // A ticker runs forever at -1, else only while its count is positive
   assign forever_run = (rep_ff == REPEAT_FOREVER);
   assign active      = forever_run || (!rep_ff[CNT16_W-1] && (rep_ff != '0));

   // Fire when visited with delay spent and period countdown at zero
   assign fire_o = visit_i && active && (delay_ff == '0) && (left_ff == '0);

   // Next-state update for a load or a visit
   always_comb begin
      delay_in  = delay_ff;
      left_in   = left_ff;
      reload_in = reload_ff;
      rep_in    = rep_ff;
      if (load_we) begin
         delay_in  = load_data.delay;
         left_in   = '0;
         reload_in = load_data.period;
         rep_in    = load_data.repeats;
      end else if (visit_i && active) begin
         if (delay_ff != '0) begin
            delay_in = delay_ff - 16'd1;
         end else if (left_ff == '0) begin
            left_in = reload_ff;
            if (!forever_run) begin
               rep_in = rep_ff - 16'sd1;
            end
         end else begin
            left_in = left_ff - 16'd1;
         end
      end
   end

   // Ticker state and token register
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= '0;
         left_ff   <= '0;
         reload_ff <= '0;
         rep_ff    <= '0;
         visit_ff  <= 1'b0;
      end else begin
         delay_ff  <= delay_in;
         left_ff   <= left_in;
         reload_ff <= reload_in;
         rep_ff    <= rep_in;
         visit_ff  <= visit_i;
      end
   end

   assign visit_o = visit_ff;

endmodule : ptb_cell

`default_nettype wire

// ===== hdl/ptb_ctrl.sv =====
// Request sequencer and fire result collector for the ticker bank.
`default_nettype none

module ptb_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       req_kind,
   input  wire logic                       chain_end,
   input  wire logic                       fire_any,
   output logic                            busy,
   output ptb_pkg::ptb_ctl_type            ctl,
   output logic                            rsp_strobe,
   output logic [ptb_pkg::FIRE_W-1:0]      rsp_fired_ticker,
   output logic                            rsp_last_fire
);
   import ptb_pkg::*;

   ptb_state_type    state_ff, state_in;
   logic             go_ff, go_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [RES_W-1:0] cnt_ff, cnt_in;
   logic             hold_valid_ff, hold_valid_in;
   logic [IDX_W-1:0] hold_idx_ff, hold_idx_in;
   logic             strobe_ff, strobe_in;
   logic             last_ff, last_in;
   logic [IDX_W-1:0] out_idx_ff, out_idx_in;
   logic [IDX_W+FIRE_W-1:0] out_wide;
   logic             accept;
   logic             tick_accept;
   logic             record;

   assign accept      = start && (state_ff == ST_IDLE);
   assign tick_accept = accept && (req_kind == KIND_TICK);
   assign record      = fire_any && (cnt_ff < RES_W'(MAX_RESULTS));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (tick_accept) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (chain_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      busy         = 1'b0;
      ctl.load_go  = 1'b0;
      ctl.sweep_go = go_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.load_go = accept && (req_kind == KIND_LOAD);
         end
         ST_SWEEP: begin
            busy = 1'b1;
         end
         default: busy = 1'b0;
      endcase
   end

   assign go_in = tick_accept;

   // Visited index, fire count, held result and result register
   always_comb begin
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      hold_valid_in = hold_valid_ff;
      hold_idx_in   = hold_idx_ff;
      strobe_in     = 1'b0;
      last_in       = 1'b0;
      out_idx_in    = out_idx_ff;
      if (tick_accept) begin
         idx_in = '0;
      end else if (state_ff == ST_SWEEP) begin
         idx_in = idx_ff + 1'b1;
      end
      // A new fire releases the previous one as not last
      if (record) begin
         cnt_in        = cnt_ff + 1'b1;
         hold_valid_in = 1'b1;
         hold_idx_in   = idx_ff;
         if (hold_valid_ff) begin
            strobe_in  = 1'b1;
            out_idx_in = hold_idx_ff;
         end
      end
      // End of sweep flushes the held fire as last
      if (chain_end) begin
         cnt_in        = '0;
         hold_valid_in = 1'b0;
         if (hold_valid_ff) begin
            strobe_in  = 1'b1;
            last_in    = 1'b1;
            out_idx_in = hold_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         go_ff         <= 1'b0;
         cnt_ff        <= '0;
         hold_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         go_ff         <= go_in;
         cnt_ff        <= cnt_in;
         hold_valid_ff <= hold_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      hold_idx_ff <= hold_idx_in;
      last_ff     <= last_in;
      out_idx_ff  <= out_idx_in;
   end

   // Result ports: low bits of the ticker index
   assign out_wide         = {{FIRE_W{1'b0}}, out_idx_ff};
   assign rsp_strobe       = strobe_ff;
   assign rsp_fired_ticker = out_wide[FIRE_W-1:0];
   assign rsp_last_fire    = last_ff;

   // Checks
   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("held fire left over outside a sweep");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RES_W'(MAX_RESULTS))
      else $error("fire count beyond result limit");
   a_fire_in_sweep: assert property (@(posedge clock) disable iff (reset)
      fire_any |-> (state_ff == ST_SWEEP))
      else $error("ticker fired outside a sweep");
   a_end_in_sweep: assert property (@(posedge clock) disable iff (reset)
      chain_end |=> (state_ff == ST_IDLE))
      else $error("sweep did not close at chain end");

endmodule : ptb_ctrl

`default_nettype wire

// ===== hdl/periodic_ticker_bank_top.sv =====
// Top level of the periodic ticker bank: cell row plus sequencer.
`default_nettype none

// A load request (req_kind 1) is taken while idle and busy stays low;
// req_ticker_sel covers exactly the TICKER_COUNT tickers. A tick request
// (req_kind 0) sends a visit token down the row of ticker cells, one cell
// per cycle, so busy stays high after the tick is taken until the token has
// passed the last cell. Fires come out in ticker order on rsp_strobe, one
// cycle each and at most MAX_RESULTS per tick; each fire is held until the
// next fire of the same tick or the end of the sweep, so that rsp_last_fire
// can mark the final one, and the last of a tick appears in the same cycle that busy falls.
// The receiver cannot stall the result port.
module periodic_ticker_bank_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_kind,
   input  wire logic [ptb_pkg::SEL_W-1:0]         req_ticker_sel,
   input  wire logic [ptb_pkg::CNT16_W-1:0]       req_start_delay,
   input  wire logic [ptb_pkg::CNT16_W-1:0]       req_period_ticks,
   input  wire logic signed [ptb_pkg::CNT16_W-1:0] req_repeat_count,
   output logic                                   rsp_strobe,
   output logic [ptb_pkg::FIRE_W-1:0]             rsp_fired_ticker,
   output logic                                   rsp_last_fire
);
   import ptb_pkg::*;

   ptb_ctl_type             ctl;
   ptb_load_type            load_data;
   logic [TICKER_COUNT:0]   visit;
   logic [TICKER_COUNT-1:0] fire_vec;

   assign load_data.delay   = req_start_delay;
   assign load_data.period  = req_period_ticks;
   assign load_data.repeats = req_repeat_count;

   // Token enters the row at cell 0
   assign visit[0] = ctl.sweep_go;

   // Row of ticker cells
   for (genvar k = 0; k < TICKER_COUNT; k++) begin : g_cell
      logic we;
      assign we = ctl.load_go && (32'(req_ticker_sel) == k);
      ptb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load_we   (we),
         .load_data (load_data),
         .visit_i   (visit[k]),
         .visit_o   (visit[k+1]),
         .fire_o    (fire_vec[k])
      );
   end

   ptb_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_kind         (req_kind),
      .chain_end        (visit[TICKER_COUNT]),
      .fire_any         (|fire_vec),
      .busy             (busy),
      .ctl              (ctl),
      .rsp_strobe       (rsp_strobe),
      .rsp_fired_ticker (rsp_fired_ticker),
      .rsp_last_fire    (rsp_last_fire)
   );

   // Checks
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(visit))
      else $error("more than one visit token in the cell row");
   a_one_fire: assert property (@(posedge clock) disable iff (reset)
      $onehot0(fire_vec))
      else $error("more than one ticker fired in a cycle");
   a_no_load_in_sweep: assert property (@(posedge clock) disable iff (reset)
      busy |-> !ctl.load_go)
      else $error("load taken during a sweep");

endmodule : periodic_ticker_bank_top

`default_nettype wire
